[design/sfla_pkg.sv]
package sfla_pkg;

    localparam int SLOTS  = 256;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [1:0]        opcode_t;
    typedef logic [1:0]        status_t;

    localparam cnt_t CAP_MAX = cnt_t'(SLOTS);

    localparam opcode_t OP_ALLOC   = 2'd0;
    localparam opcode_t OP_RELEASE = 2'd1;
    localparam opcode_t OP_QUERY   = 2'd2;
    localparam opcode_t OP_CLEAR   = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_BAD   = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

[design/sfla_ram.sv]
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/sorted_free_list_slot_allocator.sv]
// Query, clear, bad release and allocate at the terminator: the word is taken in S_IDLE,
// run in S_EXEC and its result registered from S_RESP; the next input word is taken back
// in S_IDLE. Allocate from a linked node adds S_ALOAD for the link memory read. A good
// release above the list head walks the free list one link per cycle through the single
// read port of the link memory. A stalled result word holds the block in S_RESP.
// Reset (async, active low) sets capacity to 256 and frees every slot; no clearing pass.
module sorted_free_list_slot_allocator
    import sfla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  cnt_t    cfg_wdata,
    input  logic    in_valid,
    output logic    in_stall,
    input  opcode_t opcode,
    input  slot_t   slot_index,
    output logic    out_valid,
    input  logic    out_stall,
    output slot_t   granted_index,
    output status_t status,
    output logic    slot_active,
    output logic    slot_end_of_data,
    output cnt_t    active_count,
    output cnt_t    free_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_ALOAD = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]       state_reg, state_next;
    cnt_t             cap_reg, cap_next;
    logic             term_valid_reg, term_valid_next;
    slot_t            term_pos_reg, term_pos_next;
    slot_t            head_reg, head_next;
    logic             list_empty_reg, list_empty_next;
    cnt_t             total_reg, total_next;
    opcode_t          op_reg, op_next;
    slot_t            idx_reg, idx_next;
    slot_t            cur_reg, cur_next;
    slot_t            res_granted_reg, res_granted_next;
    status_t          res_status_reg, res_status_next;
    logic             res_active_reg, res_active_next;
    logic             res_eod_reg, res_eod_next;
    logic             out_valid_reg, out_valid_next;
    slot_t            out_granted_reg, out_granted_next;
    status_t          out_status_reg, out_status_next;
    logic             out_active_reg, out_active_next;
    logic             out_eod_reg, out_eod_next;
    cnt_t             out_count_reg, out_count_next;
    cnt_t             out_free_reg, out_free_next;

    logic  ram_we;
    slot_t ram_waddr;
    cnt_t  ram_wdata;
    slot_t ram_raddr;
    cnt_t  ram_rdata;
    logic  free_we;
    slot_t free_waddr;
    logic  free_wdata;
    slot_t free_raddr;
    logic  free_rdata;
    logic  free_now;
    cnt_t  idx_ext;
    cnt_t  head_inc;
    logic  do_clear;

    sfla_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slots at or above the terminator read as free; below it the mark was written
    sfla_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    assign idx_ext    = {1'b0, idx_reg};
    assign head_inc   = cnt_t'({1'b0, head_reg} + 1'b1);
    assign in_stall   = (state_reg != S_IDLE);
    assign free_raddr = (state_reg == S_IDLE) ? slot_index : idx_reg;
    assign free_now   = (term_valid_reg && (idx_reg >= term_pos_reg)) || free_rdata;

    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        term_valid_next  = term_valid_reg;
        term_pos_next    = term_pos_reg;
        head_next        = head_reg;
        list_empty_next  = list_empty_reg;
        total_next       = total_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        res_active_next  = res_active_reg;
        res_eod_next     = res_eod_reg;
        out_valid_next   = out_valid_reg & out_stall;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_active_next  = out_active_reg;
        out_eod_next     = out_eod_reg;
        out_count_next   = out_count_reg;
        out_free_next    = out_free_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = cap_reg;
        ram_raddr        = head_reg;
        free_we          = 1'b0;
        free_waddr       = idx_reg;
        free_wdata       = 1'b1;
        do_clear         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    idx_next   = slot_index;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_granted_next = '0;
                res_status_next  = ST_OK;
                res_active_next  = 1'b0;
                res_eod_next     = 1'b0;
                state_next       = S_RESP;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (list_empty_reg || ({1'b0, head_reg} >= cap_reg))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else if (term_valid_reg && (term_pos_reg == head_reg))
                        begin
                            if (head_inc < cap_reg)
                            begin
                                head_next     = head_inc[SLOT_W-1:0];
                                term_pos_next = head_inc[SLOT_W-1:0];
                            end
                            else
                            begin
                                list_empty_next = 1'b1;
                                term_valid_next = 1'b0;
                            end
                            free_we          = 1'b1;
                            free_waddr       = head_reg;
                            free_wdata       = 1'b0;
                            total_next       = cnt_t'(total_reg + 1'b1);
                            res_granted_next = head_reg;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = S_ALOAD;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (idx_ext >= cap_reg)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else if (free_now)
                        begin
                            res_status_next = ST_BAD;
                        end
                        else
                        begin
                            free_we = 1'b1;
                            if (total_reg != '0)
                            begin
                                total_next = cnt_t'(total_reg - 1'b1);
                            end
                            if (list_empty_reg)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = cap_reg;
                                head_next       = idx_reg;
                                list_empty_next = 1'b0;
                            end
                            else if (idx_reg < head_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b0, head_reg};
                                head_next = idx_reg;
                            end
                            else if (term_valid_reg && (term_pos_reg == head_reg))
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = cap_reg;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                ram_raddr  = head_reg;
                                state_next = S_WALK;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (idx_ext >= cap_reg)
                        begin
                            res_status_next = ST_RANGE;
                        end
                        else
                        begin
                            res_active_next = ~free_now;
                            res_eod_next    = term_valid_reg && (term_pos_reg == idx_reg);
                        end
                    end
                    default:
                    begin
                        do_clear = 1'b1;
                    end
                endcase
            end
            S_ALOAD:
            begin
                if (ram_rdata >= cap_reg)
                begin
                    list_empty_next = 1'b1;
                end
                else
                begin
                    head_next = ram_rdata[SLOT_W-1:0];
                end
                free_we          = 1'b1;
                free_waddr       = head_reg;
                free_wdata       = 1'b0;
                total_next       = cnt_t'(total_reg + 1'b1);
                res_granted_next = head_reg;
                state_next       = S_RESP;
            end
            S_WALK:
            begin
                if ((ram_rdata >= cap_reg) || (ram_rdata > idx_ext))
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    state_next = S_LINK;
                end
                else if (term_valid_reg && (term_pos_reg == ram_rdata[SLOT_W-1:0]))
                begin
                    cur_next   = ram_rdata[SLOT_W-1:0];
                    ram_we     = 1'b1;
                    ram_wdata  = cap_reg;
                    state_next = S_RESP;
                end
                else
                begin
                    cur_next  = ram_rdata[SLOT_W-1:0];
                    ram_raddr = ram_rdata[SLOT_W-1:0];
                end
            end
            S_LINK:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = idx_ext;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    out_active_next  = res_active_reg;
                    out_eod_next     = res_eod_reg;
                    out_count_next   = total_reg;
                    out_free_next    = cnt_t'(cap_reg - total_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            do_clear = 1'b1;
            if (cfg_wdata == '0)
            begin
                cap_next = cnt_t'(1);
            end
            else if (cfg_wdata > CAP_MAX)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = cfg_wdata;
            end
        end

        if (do_clear)
        begin
            term_valid_next = 1'b1;
            term_pos_next   = '0;
            head_next       = '0;
            list_empty_next = 1'b0;
            total_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CAP_MAX;
            term_valid_reg <= 1'b1;
            term_pos_reg   <= '0;
            head_reg       <= '0;
            list_empty_reg <= 1'b0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            term_valid_reg <= term_valid_next;
            term_pos_reg   <= term_pos_next;
            head_reg       <= head_next;
            list_empty_reg <= list_empty_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        cur_reg         <= cur_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        res_active_reg  <= res_active_next;
        res_eod_reg     <= res_eod_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
        out_active_reg  <= out_active_next;
        out_eod_reg     <= out_eod_next;
        out_count_reg   <= out_count_next;
        out_free_reg    <= out_free_next;
    end

    assign out_valid        = out_valid_reg;
    assign granted_index    = out_granted_reg;
    assign status           = out_status_reg;
    assign slot_active      = out_active_reg;
    assign slot_end_of_data = out_eod_reg;
    assign active_count     = out_count_reg;
    assign free_count       = out_free_reg;

    a_term_order: assert property (@(posedge clk) disable iff (!rst_n)
        term_valid_reg |-> ((term_pos_reg >= head_reg) && ({1'b0, term_pos_reg} < cap_reg)))
        else $error("terminator below list head or beyond capacity");

    a_empty_no_term: assert property (@(posedge clk) disable iff (!rst_n)
        list_empty_reg |-> !term_valid_reg)
        else $error("terminator present on empty list");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        !list_empty_reg |-> ({1'b0, head_reg} < cap_reg))
        else $error("list head not below capacity");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= cap_reg)
        else $error("active count above capacity");

endmodule

[tb/tb_sorted_free_list_slot_allocator.sv]
module tb_sorted_free_list_slot_allocator
    import sfla_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT           = 3_000_000;
    localparam int ITEMS_PER_PHASE = 136;

    typedef struct packed {
        slot_t   granted;
        status_t st;
        logic    act;
        logic    eod;
        cnt_t    used;
        cnt_t    spare;
    } reply_t;

    typedef struct {
        bit      is_cfg;
        int      arg;
        opcode_t op;
        bit      typed;
        reply_t  want;
    } step_t;

    logic    clk              = 1'b0;
    logic    rst_n            = 1'b0;
    logic    cfg_we           = 1'b0;
    cnt_t    cfg_wdata        = '0;
    logic    in_valid         = 1'b0;
    logic    in_stall;
    opcode_t opcode           = OP_ALLOC;
    slot_t   slot_index       = '0;
    logic    out_valid;
    logic    out_stall        = 1'b0;
    slot_t   granted_index;
    status_t status;
    logic    slot_active;
    logic    slot_end_of_data;
    cnt_t    active_count;
    cnt_t    free_count;

    // allocator image
    int   nxt_of [SLOTS];
    bit   free_of [SLOTS];
    bit   term_of [SLOTS];
    int   head;
    int   held;
    bit   empty_list;
    cnt_t cap_cfg;

    reply_t due_replies[$];
    reply_t head_reply;
    step_t  script[$];
    int     fails     = 0;
    int     cycles    = 0;
    bit     calm      = 1'b0;
    int     stall_run = 0;
    bit     stall_val = 1'b0;
    int     stall_pick;

    sorted_free_list_slot_allocator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .slot_index       (slot_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .granted_index    (granted_index),
        .status           (status),
        .slot_active      (slot_active),
        .slot_end_of_data (slot_end_of_data),
        .active_count     (active_count),
        .free_count       (free_count)
    );

    always #1 clk = ~clk;

    function automatic void wipe_table();
        for (int s = 0; s < SLOTS; s++)
        begin
            nxt_of[s]  = 0;
            free_of[s] = 1'b1;
            term_of[s] = 1'b0;
        end
        term_of[0] = 1'b1;
        head       = 0;
        held       = 0;
        empty_list = 1'b0;
    endfunction

    function automatic int live_cap();
        if (cap_cfg == 0)
            return 1;
        if (cap_cfg > CAP_MAX)
            return SLOTS;
        return int'(cap_cfg);
    endfunction

    function automatic reply_t model_word(opcode_t op, slot_t idx);
        reply_t r;
        int     cap;
        int     slot;
        int     cur;
        int     nxt;
        r    = '0;
        cap  = live_cap();
        slot = int'(idx);
        case (op)
            OP_ALLOC:
            begin
                if (empty_list || head >= cap)
                    r.st = ST_FULL;
                else
                begin
                    cur = head;
                    if (term_of[cur])
                    begin
                        term_of[cur] = 1'b0;
                        if (cur + 1 < cap)
                        begin
                            head             = cur + 1;
                            term_of[cur + 1] = 1'b1;
                        end
                        else
                            empty_list = 1'b1;
                    end
                    else
                    begin
                        nxt = nxt_of[cur];
                        if (nxt >= cap)
                            empty_list = 1'b1;
                        else
                            head = nxt;
                    end
                    free_of[cur] = 1'b0;
                    held++;
                    r.granted = slot_t'(cur);
                end
            end
            OP_RELEASE:
            begin
                if (slot >= cap)
                    r.st = ST_RANGE;
                else if (free_of[slot])
                    r.st = ST_BAD;
                else
                begin
                    free_of[slot] = 1'b1;
                    term_of[slot] = 1'b0;
                    if (held > 0)
                        held--;
                    if (empty_list)
                    begin
                        nxt_of[slot] = cap;
                        head         = slot;
                        empty_list   = 1'b0;
                    end
                    else if (slot < head)
                    begin
                        nxt_of[slot] = head;
                        head         = slot;
                    end
                    else
                    begin
                        cur = head;
                        for (int k = 0; k < cap; k++)
                        begin
                            if (term_of[cur])
                                break;
                            nxt = nxt_of[cur];
                            if (nxt >= cap || nxt > slot)
                                break;
                            cur = nxt;
                        end
                        if (term_of[cur])
                            nxt_of[slot] = cap;
                        else
                        begin
                            nxt_of[slot] = nxt_of[cur];
                            nxt_of[cur]  = slot;
                        end
                    end
                end
            end
            OP_QUERY:
            begin
                if (slot >= cap)
                    r.st = ST_RANGE;
                else
                begin
                    r.act = !free_of[slot];
                    r.eod = term_of[slot];
                end
            end
            default:
                wipe_table();
        endcase
        r.used  = cnt_t'(held);
        r.spare = cnt_t'(cap - held);
        return r;
    endfunction

    function automatic void row(bit is_cfg, int arg, opcode_t op, bit typed, int g,
                                status_t s, bit a, bit e, int u, int f);
        step_t t;
        t.is_cfg = is_cfg;
        t.arg    = arg;
        t.op     = op;
        t.typed  = typed;
        t.want   = '{slot_t'(g), s, a, e, cnt_t'(u), cnt_t'(f)};
        script.push_back(t);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        fails++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_word(opcode_t op, slot_t idx, bit typed, reply_t typed_reply);
        reply_t r;
        in_valid   <= 1'b1;
        opcode     <= op;
        slot_index <= idx;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        r = model_word(op, idx);
        due_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic pause_sender();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(int value);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt_t'(value);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cap_cfg = cnt_t'(value);
        wipe_table();
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50)
            begin
                stall_val = 1'b0;
                stall_run = $urandom_range(1, 40);
            end
            else if (stall_pick < 90)
            begin
                stall_val = 1'b1;
                stall_run = $urandom_range(1, 3);
            end
            else
            begin
                stall_val = 1'b1;
                stall_run = $urandom_range(10, 40);
            end
        end
        stall_run--;
        out_stall <= stall_val;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_replies.size() == 0)
                flag_mismatch("unexpected word", 1, 0);
            else
            begin
                head_reply = due_replies.pop_front();
                if (granted_index !== head_reply.granted)
                    flag_mismatch("granted_index", granted_index, head_reply.granted);
                if (status !== head_reply.st)
                    flag_mismatch("status", status, head_reply.st);
                if (slot_active !== head_reply.act)
                    flag_mismatch("slot_active", slot_active, head_reply.act);
                if (slot_end_of_data !== head_reply.eod)
                    flag_mismatch("slot_end_of_data", slot_end_of_data, head_reply.eod);
                if (active_count !== head_reply.used)
                    flag_mismatch("active_count", active_count, head_reply.used);
                if (free_count !== head_reply.spare)
                    flag_mismatch("free_count", free_count, head_reply.spare);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int      phase_caps[12];
        int      live;
        int      n_act;
        int      k;
        int      mode;
        int      span;
        int      pick;
        int      alloc_pct;
        opcode_t op;
        slot_t   idx;

        phase_caps = '{1, 4, 256, 2, 17, 511, 9, 300, 64, 3, 256, 33};
        cap_cfg    = CAP_MAX;
        wipe_table();

        // after reset: full 256-slot table
        row(0,   0, OP_QUERY,   1, 0, ST_OK,    0, 1, 0, 256);
        row(0,   0, OP_RELEASE, 1, 0, ST_BAD,   0, 0, 0, 256);
        row(0,   0, OP_ALLOC,   1, 0, ST_OK,    0, 0, 1, 255);
        row(0,   0, OP_ALLOC,   1, 1, ST_OK,    0, 0, 2, 254);
        row(0,   0, OP_QUERY,   1, 0, ST_OK,    1, 0, 2, 254);
        row(0,   2, OP_QUERY,   1, 0, ST_OK,    0, 1, 2, 254);
        row(0,   0, OP_RELEASE, 1, 0, ST_OK,    0, 0, 1, 255);
        row(0,   0, OP_RELEASE, 1, 0, ST_BAD,   0, 0, 1, 255);
        row(0,   0, OP_ALLOC,   1, 0, ST_OK,    0, 0, 2, 254);
        row(0, 255, OP_CLEAR,   1, 0, ST_OK,    0, 0, 0, 256);
        // capacity zero acts as one
        row(1,   0, OP_ALLOC,   0, 0, ST_OK,    0, 0, 0, 0);
        row(0,   0, OP_ALLOC,   1, 0, ST_OK,    0, 0, 1, 0);
        row(0,   0, OP_ALLOC,   1, 0, ST_FULL,  0, 0, 1, 0);
        row(0, 255, OP_QUERY,   1, 0, ST_RANGE, 0, 0, 1, 0);
        row(0,   1, OP_RELEASE, 1, 0, ST_RANGE, 0, 0, 1, 0);
        row(0,   0, OP_RELEASE, 1, 0, ST_OK,    0, 0, 0, 1);
        row(0,   0, OP_QUERY,   1, 0, ST_OK,    0, 0, 0, 1);
        row(0,   0, OP_ALLOC,   1, 0, ST_OK,    0, 0, 1, 0);
        // three slots: fill, release into a full table, sorted inserts
        row(1,   3, OP_ALLOC,   0, 0, ST_OK,    0, 0, 0, 0);
        row(0,   0, OP_ALLOC,   1, 0, ST_OK,    0, 0, 1, 2);
        row(0,   0, OP_ALLOC,   1, 1, ST_OK,    0, 0, 2, 1);
        row(0,   0, OP_ALLOC,   1, 2, ST_OK,    0, 0, 3, 0);
        row(0,   0, OP_ALLOC,   1, 0, ST_FULL,  0, 0, 3, 0);
        row(0,   2, OP_RELEASE, 1, 0, ST_OK,    0, 0, 2, 1);
        row(0,   0, OP_RELEASE, 0, 0, ST_OK,    0, 0, 0, 0);
        row(0,   1, OP_RELEASE, 0, 0, ST_OK,    0, 0, 0, 0);
        row(0,   0, OP_ALLOC,   0, 0, ST_OK,    0, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_capacity(script[i].arg);
            else
            begin
                send_word(script[i].op, slot_t'(script[i].arg), script[i].typed,
                          script[i].want);
                pause_sender();
            end
        end

        span = 0;
        mode = 0;
        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold off until every word is back
                if (n == 60)
                    drain_replies();
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(8, 80);
                end
                span--;
                live      = live_cap();
                alloc_pct = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
                pick      = $urandom_range(0, 99);
                idx       = slot_t'($urandom_range(0, 255));
                if (pick < 2)
                    op = OP_CLEAR;
                else if (pick < 2 + alloc_pct)
                    op = OP_ALLOC;
                else if (pick < 14 + alloc_pct)
                begin
                    op = OP_QUERY;
                    if ($urandom_range(0, 99) < 75)
                        idx = slot_t'($urandom_range(0, live - 1));
                end
                else
                begin
                    op    = OP_RELEASE;
                    n_act = 0;
                    for (int s = 0; s < live; s++)
                        if (!free_of[s])
                            n_act++;
                    if (n_act > 0 && $urandom_range(0, 99) < 85)
                    begin
                        k = $urandom_range(0, n_act - 1);
                        for (int s = 0; s < live; s++)
                        begin
                            if (!free_of[s])
                            begin
                                if (k == 0)
                                    idx = slot_t'(s);
                                k--;
                            end
                        end
                    end
                end
                send_word(op, idx, 1'b0, '0);
                pause_sender();
            end
        end

        drain_replies();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
design/sfla_pkg.sv
design/sfla_ram.sv
design/sorted_free_list_slot_allocator.sv
tb/tb_sorted_free_list_slot_allocator.sv
